// ----- hw/rtl/sih_pkg.sv -----
// Shared types, codes and helpers for the sampled IPC histogram.
`default_nettype none
package sih_pkg;

  localparam int HIST_NUM = 3;

  localparam logic       OP_SAMPLE      = 1'b0;
  localparam logic       OP_READ        = 1'b1;
  localparam logic [7:0] STATUS_RUNNING = 8'd1;
  localparam logic [31:0] IPC_LIMIT     = 32'd1000;

  // histogram selector codes, also the divider lane order
  localparam logic [1:0] SEL_CORE = 2'd0;
  localparam logic [1:0] SEL_APP  = 2'd1;
  localparam logic [1:0] SEL_SELF = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [63:0] cycle_count;
    logic [63:0] core_instr_count;
    logic [63:0] self_instr_count;
    logic        trustable;
    logic [7:0]  exec_status;
    logic [9:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic        taken;
    logic        interesting;
    logic [31:0] bin_core;
    logic [31:0] bin_app;
    logic [31:0] bin_self;
    logic [63:0] total_samples;
    logic [63:0] bad_samples;
    logic [63:0] good_samples;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_JUDGE,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // x * 100 mod 2^32 as shifts and adds
  function automatic logic [31:0] scale_hundred(input logic [31:0] x);
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sih_div.sv -----
// Restoring divider, one quotient bit per cycle, three numerator lanes on one divisor.
`default_nettype none
module sih_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [sih_pkg::HIST_NUM-1:0][31:0] num,
  input  wire logic [31:0]                        den,
  output sih_pkg::div_stat_t                      stat,
  output logic      [sih_pkg::HIST_NUM-1:0][31:0] quot
);
  import sih_pkg::*;

  logic                        busy_r;
  logic                        done_r;
  logic [4:0]                  cnt_r;
  logic [31:0]                 den_r;
  logic [HIST_NUM-1:0][31:0]   rem_r;
  logic [HIST_NUM-1:0][31:0]   quo_r;
  logic [HIST_NUM-1:0][31:0]   rem_nxt;
  logic [HIST_NUM-1:0][31:0]   quo_nxt;
  logic [HIST_NUM-1:0][32:0]   trial;

  always_comb begin
    for (int i = 0; i < HIST_NUM; i++) begin
      trial[i] = {rem_r[i], quo_r[i][31]};
      if (trial[i] >= {1'b0, den_r}) begin
        rem_nxt[i] = 32'(trial[i] - {1'b0, den_r});
        quo_nxt[i] = {quo_r[i][30:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][31:0];
        quo_nxt[i] = {quo_r[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == 5'd0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      quo_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sih_ram.sv -----
// Simple dual-port histogram memory, registered read.
`default_nettype none
module sih_ram #(
  parameter int AW    = 12,
  parameter int DEPTH = 3072,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sampled_ipc_histogram.sv -----
// Top level: sampled IPC histogram controller, counters and result register.
//
//  port group   dir  handshake          payload
//  in_*         in   in_valid/in_ready  sih_pkg::in_item_t
//  out_*        out  out_valid/out_ready sih_pkg::out_item_t
//  cfg_*        in   cfg_we (no wait)   cfg_wdata = decimation rate
//
// After reset the histogram memory, 3 * 2**ceil(log2(NUM_BINS)) entries
// (3072 at 1024 bins), is swept to zero, one entry a cycle; in_ready stays low.
// Per item: a reference or non-taken sample goes straight from idle to done;
// a zero cycle delta passes prep only; a read reads three bins in turn; a
// taken sample runs prep, the 32-step divider forming the three IPC quotients
// together, judge and, if binned, a read-modify-write of three bins.
// A finished item sits in the output register; the next item is accepted
// while it waits, and a later result stalls only if it is still not taken.
`default_nettype none
module sampled_ipc_histogram #(
  parameter int NUM_BINS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sih_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sih_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);
  import sih_pkg::*;

  localparam int AW        = $clog2(NUM_BINS);
  localparam int MAW       = AW + 2;
  localparam int MEM_DEPTH = HIST_NUM * (1 << AW);
  localparam logic [MAW-1:0] CLR_LAST = MAW'(MEM_DEPTH - 1);
  localparam logic [31:0]    BINS32   = 32'(NUM_BINS);

  state_t state_r, state_nxt;

  // control / counters
  logic [15:0]    rate_r;
  logic [15:0]    steps_r;
  logic           have_ref_r;
  logic [31:0]    ref_cyc_r, ref_core_r, ref_self_r;
  logic [63:0]    sample_total_r, bad_total_r, good_total_r;
  logic [MAW-1:0] clr_cnt_r;
  logic           out_valid_r;

  // per-item working registers
  logic [31:0]    dcyc_r, dcore_r, dself_r;
  logic           trust_r, run_r;
  logic           taken_r, inter_r;
  logic           rmw_r;
  logic [1:0]     sel_r;
  logic [AW-1:0]  rd_idx_r;
  logic           idx_ok_r;
  logic [HIST_NUM-1:0][31:0] bin_r;
  out_item_t      out_data_r;

  // datapath wires
  logic                      accept;
  logic                      is_taken;
  logic                      good;
  logic                      can_load;
  logic [31:0]               dapp;
  logic [HIST_NUM-1:0][31:0] div_num;
  logic [HIST_NUM-1:0][31:0] div_quot;
  div_stat_t                 div_stat;
  logic                      div_start;
  logic [AW-1:0]             bin_idx;
  logic                      mem_we, mem_re;
  logic [MAW-1:0]            mem_waddr, mem_raddr;
  logic [31:0]               mem_wdata, mem_rdata;

  assign accept   = in_valid && in_ready;
  assign is_taken = (steps_r <= 16'd1);
  assign can_load = !out_valid_r || out_ready;

  assign dapp = dcore_r - dself_r;
  always_comb begin
    div_num[SEL_CORE] = scale_hundred(dcore_r);
    div_num[SEL_APP]  = scale_hundred(dapp);
    div_num[SEL_SELF] = scale_hundred(dself_r);
  end

  // binning rule: quotients are final while in ST_JUDGE
  assign good = trust_r && run_r &&
                (div_quot[SEL_CORE] <= IPC_LIMIT) &&
                (div_quot[SEL_CORE] < BINS32) &&
                (div_quot[SEL_SELF] <= div_quot[SEL_APP]) &&
                (div_quot[SEL_APP] < BINS32);

  // bin address: histogram select in the top bits
  assign bin_idx = rmw_r ? div_quot[sel_r][AW-1:0] : rd_idx_r;

  sih_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dcyc_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  sih_ram #(
    .AW    (MAW),
    .DEPTH (MEM_DEPTH),
    .DW    (32)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_READ) begin
            state_nxt = ST_RD;
          end else if (have_ref_r && is_taken) begin
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        state_nxt = (dcyc_r == 32'd0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        state_nxt = good ? ST_RD : ST_DONE;
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        state_nxt = (sel_r == SEL_SELF) ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {sel_r, bin_idx};
    mem_raddr = {sel_r, bin_idx};
    mem_wdata = (mem_rdata == 32'hFFFF_FFFF) ? mem_rdata : mem_rdata + 32'd1;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_PREP: begin
        div_start = (dcyc_r != 32'd0);
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      ST_WR: begin
        mem_we = rmw_r;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      rate_r         <= 16'd1;
      steps_r        <= 16'd1;
      have_ref_r     <= 1'b0;
      ref_cyc_r      <= '0;
      ref_core_r     <= '0;
      ref_self_r     <= '0;
      sample_total_r <= '0;
      bad_total_r    <= '0;
      good_total_r   <= '0;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + MAW'(1);

      if (accept && in_data.operation == OP_SAMPLE) begin
        if (!have_ref_r) begin
          have_ref_r <= 1'b1;
          ref_cyc_r  <= in_data.cycle_count[31:0];
          ref_core_r <= in_data.core_instr_count[31:0];
          ref_self_r <= in_data.self_instr_count[31:0];
        end else begin
          sample_total_r <= sample_total_r + 64'd1;
          if (is_taken) begin
            ref_cyc_r  <= in_data.cycle_count[31:0];
            ref_core_r <= in_data.core_instr_count[31:0];
            ref_self_r <= in_data.self_instr_count[31:0];
          end
        end
      end

      // zero cycle delta is rejected without dividing
      if (state_r == ST_PREP && dcyc_r == 32'd0) bad_total_r <= bad_total_r + 64'd1;
      if (state_r == ST_JUDGE) begin
        if (good) begin
          good_total_r <= good_total_r + 64'd1;
        end else begin
          bad_total_r <= bad_total_r + 64'd1;
        end
      end

      // a rate write restarts the decimation period
      if (cfg_we) begin
        rate_r  <= cfg_wdata;
        steps_r <= cfg_wdata;
      end else if (accept && in_data.operation == OP_SAMPLE && have_ref_r) begin
        steps_r <= is_taken ? rate_r : steps_r - 16'd1;
      end

      if (state_r == ST_DONE && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      taken_r  <= (in_data.operation == OP_SAMPLE) && have_ref_r && is_taken;
      inter_r  <= 1'b0;
      rmw_r    <= 1'b0;
      sel_r    <= SEL_CORE;
      bin_r    <= '0;
      trust_r  <= in_data.trustable;
      run_r    <= (in_data.exec_status == STATUS_RUNNING);
      rd_idx_r <= AW'(in_data.bin_index);
      idx_ok_r <= (32'(in_data.bin_index) < BINS32);
      dcyc_r   <= in_data.cycle_count[31:0] - ref_cyc_r;
      dcore_r  <= in_data.core_instr_count[31:0] - ref_core_r;
      dself_r  <= in_data.self_instr_count[31:0] - ref_self_r;
    end
    if (state_r == ST_JUDGE && good) begin
      inter_r <= 1'b1;
      rmw_r   <= 1'b1;
      sel_r   <= SEL_CORE;
    end
    if (state_r == ST_WR) begin
      if (!rmw_r) bin_r[sel_r] <= idx_ok_r ? mem_rdata : 32'd0;
      sel_r <= sel_r + 2'd1;
    end
    if (state_r == ST_DONE && can_load) begin
      out_data_r.taken         <= taken_r;
      out_data_r.interesting   <= inter_r;
      out_data_r.bin_core      <= bin_r[SEL_CORE];
      out_data_r.bin_app       <= bin_r[SEL_APP];
      out_data_r.bin_self      <= bin_r[SEL_SELF];
      out_data_r.total_samples <= sample_total_r;
      out_data_r.bad_samples   <= bad_total_r;
      out_data_r.good_samples  <= good_total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // memory is only written by the sweep or the increment step
  a_mem_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || (state_r == ST_WR && rmw_r)))
    else $error("histogram write outside sweep or increment");

  // divider is never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a binned item is always a taken one
  a_inter_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.interesting) |-> out_data.taken)
    else $error("interesting item not marked taken");

  // judging a good sample bumps the good count by exactly one
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUDGE && good) |=> (good_total_r == $past(good_total_r) + 64'd1))
    else $error("good count not advanced");

endmodule
`default_nettype wire
